// ===== rtl/clcd_pkg.sv =====
// Shared types and constants for the character LCD text and cursor writer.
// Holds the queue entry type that passes decoded nibble bytes from front to back.
// No dependencies.
package clcd_pkg;

    // Stream widths on the top-level ports.
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 8;
    localparam int OUT_USER_W = 2;

    // Configuration port.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_ADDR_W-1:0] REG_COLUMNS   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LINES     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_AUTO_WRAP = 2'd2;

    // Operation codes.
    localparam logic [2:0] OP_PUT   = 3'd0;
    localparam logic [2:0] OP_SET   = 3'd1;
    localparam logic [2:0] OP_LEFT  = 3'd2;
    localparam logic [2:0] OP_RIGHT = 3'd3;
    localparam logic [2:0] OP_UP    = 3'd4;
    localparam logic [2:0] OP_DOWN  = 3'd5;

    // Escape characters and the blank used by backspace.
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Display instruction encoding.
    localparam logic [7:0] DDRAM_SET  = 8'h80;
    localparam logic [7:0] ROW_ODD    = 8'h40;
    localparam logic       RS_INSTR   = 1'b0;
    localparam logic       RS_DATA    = 1'b1;

    // One transaction item yields at most this many bytes (two nibbles each).
    localparam int SLOTS  = 4;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int NIB_W  = $clog2(2 * SLOTS);

    // Decoupling queue depth.
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Decoded work for one input transaction.
    typedef struct packed {
        logic [SLOTS-1:0][7:0] bytes;
        logic [SLOTS-1:0]      rs;
        logic [CNT_W-1:0]      nbytes;
        logic                  fault;
    } entry_t;

endpackage

// ===== rtl/clcd_front.sv =====
// Front end: accepts input transactions, tracks the cursor and decodes each item
// into a list of display bytes. Holds the configuration registers.
// Depends on clcd_pkg.
module clcd_front #(
    parameter int COL_LIMIT = 20,
    parameter int ROW_LIMIT = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port.
    input  logic                             cfg_wr_en,
    input  logic [clcd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [clcd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Input stream.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [clcd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic [clcd_pkg::IN_USER_W-1:0]   s_axis_tuser,
    // Toward the queue.
    output logic                             push_valid,
    input  logic                             push_ready,
    output clcd_pkg::entry_t                 push_entry
);
    import clcd_pkg::*;

    typedef struct packed {
        logic [4:0] cols;
        logic [2:0] lines;
        logic       wrap;
    } cfg_t;

    typedef struct packed {
        logic [1:0]            row;
        logic [4:0]            col;
        logic [CNT_W-1:0]      nb;
        logic [SLOTS-1:0][7:0] bytes;
        logic [SLOTS-1:0]      rs;
        logic                  fault;
        logic                  ok;
    } work_t;

    logic [4:0] columns_reg;
    logic [2:0] lines_reg;
    logic       auto_wrap_reg;
    logic [1:0] cursor_row_reg;
    logic [4:0] cursor_column_reg;

    logic [2:0] op;
    logic [7:0] char_code;
    logic [1:0] target_row;
    logic [4:0] target_column;

    cfg_t       cfg;
    work_t      w;
    logic [1:0] pr;
    logic [5:0] pc;
    logic [8:0] tab_prod;
    logic [5:0] tab_col;
    logic       accept;

    assign op            = s_axis_tuser;
    assign char_code     = s_axis_tdata[7:0];
    assign target_row    = s_axis_tdata[9:8];
    assign target_column = s_axis_tdata[14:10];

    // Append one byte; past the slot limit the byte is dropped and flagged.
    function automatic work_t f_emit(work_t wi, logic rs, logic [7:0] b);
        work_t r;
        r = wi;
        if (r.nb == CNT_W'(SLOTS))
        begin
            r.fault = 1'b1;
        end
        else
        begin
            r.bytes[r.nb[SLOT_W-1:0]] = b;
            r.rs[r.nb[SLOT_W-1:0]]    = rs;
            r.nb                      = r.nb + CNT_W'(1);
        end
        return r;
    endfunction

    // Move the cursor and issue a set-address instruction, or flag a bad position.
    function automatic work_t f_set_pos(work_t wi, cfg_t c, logic [1:0] r, logic [5:0] col);
        work_t      res;
        logic [8:0] addr;
        res  = wi;
        addr = '0;
        if (({1'b0, r} >= c.lines) || (col >= {1'b0, c.cols}))
        begin
            res.fault = 1'b1;
            res.ok    = 1'b0;
        end
        else
        begin
            addr = {1'b0, DDRAM_SET} + (r[0] ? {1'b0, ROW_ODD} : 9'd0)
                 + (r[1] ? {4'd0, c.cols} : 9'd0) + {3'd0, col};
            res     = f_emit(res, RS_INSTR, addr[7:0]);
            res.row = r;
            res.col = col[4:0];
            res.ok  = 1'b1;
        end
        return res;
    endfunction

    function automatic work_t f_next_line(work_t wi, cfg_t c);
        work_t res;
        res = wi;
        if ({1'b0, wi.row} < (c.lines - 3'd1))
        begin
            res = f_set_pos(wi, c, wi.row + 2'd1, 6'd0);
        end
        else
        begin
            res.ok = 1'b0;
        end
        return res;
    endfunction

    // At the end of a line: wrap if enabled and a line follows, refuse on the last line.
    function automatic work_t f_end_check(work_t wi, cfg_t c);
        work_t res;
        res    = wi;
        res.ok = 1'b1;
        if (wi.col >= c.cols)
        begin
            if ({1'b0, wi.row} < (c.lines - 3'd1))
            begin
                if (c.wrap)
                begin
                    res = f_next_line(res, c);
                end
                res.ok = 1'b1;
            end
            else
            begin
                res.col = c.cols;
                res.ok  = 1'b0;
            end
        end
        return res;
    endfunction

    function automatic work_t f_write_cell(work_t wi, cfg_t c, logic [7:0] ch);
        work_t res;
        res = f_emit(wi, RS_DATA, ch);
        if (res.col < 5'd31)
        begin
            res.col = res.col + 5'd1;
        end
        res = f_end_check(res, c);
        return res;
    endfunction

    function automatic work_t f_plain_put(work_t wi, cfg_t c, logic [7:0] ch);
        work_t res;
        res = f_end_check(wi, c);
        if (!res.ok)
        begin
            res.fault = 1'b1;
        end
        else
        begin
            res = f_write_cell(res, c, ch);
        end
        return res;
    endfunction

    // Effective display size, saturated into the supported range.
    always_comb
    begin
        cfg.wrap = auto_wrap_reg;
        if (columns_reg == 5'd0)
            cfg.cols = 5'd1;
        else if (int'(columns_reg) > COL_LIMIT)
            cfg.cols = 5'(COL_LIMIT);
        else
            cfg.cols = columns_reg;
        if (lines_reg == 3'd0)
            cfg.lines = 3'd1;
        else if (int'(lines_reg) > ROW_LIMIT)
            cfg.lines = 3'(ROW_LIMIT);
        else
            cfg.lines = lines_reg;
    end

    // Next tab stop: floor(col / 3) is (col * 11) >> 5 for any 5-bit column.
    assign tab_prod = {4'd0, cursor_column_reg} * 9'd11;
    assign tab_col  = ({2'd0, tab_prod[8:5]} + 6'd1) * 6'd3;

    // Decode one item against the current cursor.
    always_comb
    begin
        w.row   = cursor_row_reg;
        w.col   = cursor_column_reg;
        w.nb    = '0;
        w.bytes = '0;
        w.rs    = '0;
        w.fault = 1'b0;
        w.ok    = 1'b0;
        pr      = '0;
        pc      = '0;
        unique case (op)
            OP_PUT:
            begin
                w = f_end_check(w, cfg);
                if (!w.ok)
                begin
                    w.fault = 1'b1;
                end
                else
                begin
                    unique case (char_code)
                        CH_LF:
                        begin
                            w = f_next_line(w, cfg);
                            if (!w.ok)
                                w.fault = 1'b1;
                        end
                        CH_BS:
                        begin
                            if (w.col != 5'd0)
                            begin
                                pr = w.row;
                                pc = {1'b0, w.col} - 6'd1;
                                w  = f_set_pos(w, cfg, pr, pc);
                                w  = f_plain_put(w, cfg, CH_SPACE);
                                w  = f_set_pos(w, cfg, pr, pc);
                            end
                            else if (w.row != 2'd0)
                            begin
                                pr = w.row - 2'd1;
                                pc = {1'b0, cfg.cols} - 6'd1;
                                w  = f_set_pos(w, cfg, pr, pc);
                                w  = f_plain_put(w, cfg, CH_SPACE);
                                w  = f_set_pos(w, cfg, pr, pc);
                            end
                            else
                            begin
                                w.fault = 1'b1;
                            end
                        end
                        CH_TAB:
                        begin
                            // The tab stop comes from the column before any wrap.
                            if (w.col == cursor_column_reg)
                                w = f_set_pos(w, cfg, w.row, tab_col);
                            else
                                w = f_set_pos(w, cfg, w.row, 6'd3);
                        end
                        CH_CR:
                        begin
                            w = f_set_pos(w, cfg, w.row, 6'd0);
                        end
                        default:
                        begin
                            w = f_write_cell(w, cfg, char_code);
                        end
                    endcase
                end
            end
            OP_SET:
            begin
                w = f_set_pos(w, cfg, target_row, {1'b0, target_column});
            end
            OP_LEFT:
            begin
                if (w.col != 5'd0)
                    w.col = w.col - 5'd1;
                w = f_set_pos(w, cfg, w.row, {1'b0, w.col});
            end
            OP_RIGHT:
            begin
                if (w.col < (cfg.cols - 5'd1))
                    w.col = w.col + 5'd1;
                else
                    w.col = cfg.cols - 5'd1;
                w = f_set_pos(w, cfg, w.row, {1'b0, w.col});
            end
            OP_UP:
            begin
                if (w.row != 2'd0)
                    w.row = w.row - 2'd1;
                w = f_set_pos(w, cfg, w.row, {1'b0, w.col});
            end
            OP_DOWN:
            begin
                if ({1'b0, w.row} < (cfg.lines - 3'd1))
                    w.row = w.row + 2'd1;
                else
                    w.row = 2'(cfg.lines - 3'd1);
                w = f_set_pos(w, cfg, w.row, {1'b0, w.col});
            end
            default:
            begin
                w.fault = 1'b1;
            end
        endcase
    end

    assign s_axis_tready     = push_ready;
    assign accept            = s_axis_tvalid && push_ready;
    assign push_valid        = s_axis_tvalid;
    assign push_entry.bytes  = w.bytes;
    assign push_entry.rs     = w.rs;
    assign push_entry.nbytes = w.nb;
    assign push_entry.fault  = w.fault;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg   <= 5'd16;
            lines_reg     <= 3'd2;
            auto_wrap_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_COLUMNS:   columns_reg   <= cfg_wdata[4:0];
                REG_LINES:     lines_reg     <= cfg_wdata[2:0];
                REG_AUTO_WRAP: auto_wrap_reg <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // Cursor state moves on every accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_row_reg    <= '0;
            cursor_column_reg <= '0;
        end
        else if (accept)
        begin
            cursor_row_reg    <= w.row;
            cursor_column_reg <= w.col;
        end
    end

endmodule

// ===== rtl/clcd_queue.sv =====
// Small FIFO that decouples the decoding front end from the nibble back end.
// Depends on clcd_pkg.
module clcd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  clcd_pkg::entry_t push_entry,
    output logic             head_valid,
    input  logic             pop,
    output clcd_pkg::entry_t head_entry
);
    import clcd_pkg::*;

    entry_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                if (wr_ptr_reg == QPTR_W'(QDEPTH - 1))
                    wr_ptr_reg <= '0;
                else
                    wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                if (rd_ptr_reg == QPTR_W'(QDEPTH - 1))
                    rd_ptr_reg <= '0;
                else
                    rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

endmodule

// ===== rtl/clcd_back.sv =====
// Back end: walks the queued byte list and drives one nibble transaction per cycle
// through a registered output stage, holding while m_axis_tready is low. Depends on clcd_pkg.
module clcd_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             head_valid,
    input  clcd_pkg::entry_t                 head_entry,
    output logic                             pop,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [clcd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic [clcd_pkg::OUT_USER_W-1:0]  m_axis_tuser,
    output logic                             m_axis_tlast
);
    import clcd_pkg::*;

    logic [NIB_W-1:0]  idx_reg;
    logic              out_valid_reg;
    logic              has_write_reg;
    logic              reg_select_reg;
    logic [3:0]        nibble_reg;
    logic              status_reg;
    logic              last_reg;

    logic              load;
    logic              is_last;
    logic              has_write;
    logic [SLOT_W-1:0] slot;
    logic [NIB_W:0]    last_idx;
    logic [7:0]        cur_byte;

    // Pick the nibble at the current position, high half first.
    assign slot      = idx_reg[NIB_W-1:1];
    assign cur_byte  = head_entry.bytes[slot];
    assign has_write = (head_entry.nbytes != '0);
    assign last_idx  = (NIB_W+1)'({head_entry.nbytes, 1'b0}) - (NIB_W+1)'(1);
    assign is_last   = !has_write || ({1'b0, idx_reg} == last_idx);
    assign load      = head_valid && (!out_valid_reg || m_axis_tready);
    assign pop       = load && is_last;

    // Position within the current entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (load)
            idx_reg <= is_last ? '0 : idx_reg + NIB_W'(1);
    end

    // Output stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // Output stage payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            has_write_reg  <= has_write;
            reg_select_reg <= has_write && head_entry.rs[slot];
            nibble_reg     <= !has_write ? 4'd0 : (idx_reg[0] ? cur_byte[3:0] : cur_byte[7:4]);
            status_reg     <= is_last && head_entry.fault;
            last_reg       <= is_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0, status_reg, nibble_reg};
    assign m_axis_tuser  = {reg_select_reg, has_write_reg};
    assign m_axis_tlast  = last_reg;

endmodule

// ===== rtl/char_lcd_text_cursor_writer.sv =====
// Top level of the character LCD text and cursor writer.
// Instantiates clcd_front, clcd_queue and clcd_back; depends on clcd_pkg.
//
// Channel   Direction  Handshake               Contents
// s_axis    in         tvalid/tready           tuser op; tdata char, row, column
// m_axis    out        tvalid/tready, tlast    tuser write flags; tdata nibble, status
// cfg       in         cfg_wr_en               cfg_addr index, cfg_wdata value
//
// The front end decodes one transaction per cycle while the two-entry queue has room.
// The back end sends one nibble transaction per cycle while m_axis_tready is high, so
// an item yields max(1, 2 * bytes) transactions, at most 8; that output rate sets the sustained rate.
// Reset clears the cursor to the origin and loads 16 columns, 2 lines, wrap on.
// A stalled output fills the queue, after which s_axis_tready drops.
module char_lcd_text_cursor_writer #(
    parameter int COL_LIMIT = 20,
    parameter int ROW_LIMIT = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [clcd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [clcd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [7:0] char_code, [9:8] target_row, [14:10] target_column, [15] zero
    input  logic [clcd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [2:0] op
    input  logic [clcd_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [3:0] nibble, [4] status, [7:5] zero
    output logic [clcd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // [0] has_write, [1] reg_select
    output logic [clcd_pkg::OUT_USER_W-1:0]  m_axis_tuser,
    output logic                             m_axis_tlast
);
    import clcd_pkg::*;

    logic   push_valid;
    logic   push_ready;
    entry_t push_entry;
    logic   head_valid;
    entry_t head_entry;
    logic   pop;

    clcd_front #(
        .COL_LIMIT (COL_LIMIT),
        .ROW_LIMIT (ROW_LIMIT)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_entry    (push_entry)
    );

    clcd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .head_valid (head_valid),
        .pop        (pop),
        .head_entry (head_entry)
    );

    clcd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_entry    (head_entry),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Status is only reported on the final transaction of an item.
    a_status_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[4]) |-> m_axis_tlast)
        else $error("status set on a transaction that is not the last");

    // A result without a write is the single result of its item.
    a_nowrite_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tlast && !m_axis_tuser[1]))
        else $error("empty result is not a lone instruction-free last transaction");

    // The input only backs up behind a held output.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled while the output stage is empty");

endmodule
